/* design/shbi_pkg.sv */
package shbi_pkg;

  // Hash and divisor widths
  localparam int HASH_W  = 64;
  localparam int DIV_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = $clog2(HASH_W);
  localparam int SHIFT_N = 5;

  localparam logic [HASH_W-1:0] HASH_SEED      = HASH_W'(5381);
  localparam logic [DIV_W-1:0]  BUCKET_RST     = DIV_W'(16);
  localparam logic [CNT_W-1:0]  DIV_LAST_STEP  = CNT_W'(HASH_W - 1);

  typedef enum logic [1:0] {
    ST_HASH,
    ST_DIV,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic hash_en;    // mix an accepted non-last beat
    logic div_start;  // last beat: mix, latch hash, start the modulo
    logic div_step;   // one remainder step
    logic out_load;   // move the finished result to the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;   // current step is the final one
    logic out_busy;   // output register holds a beat that is not taken now
  } sts_t;

  // One djb2 xor step; a zero byte leaves the hash alone
  function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] t;
    t = (h << SHIFT_N) + h;
    if (b == '0) begin
      mix_byte = h;
    end else begin
      mix_byte = t ^ {{(HASH_W-BYTE_W){1'b0}}, b};
    end
  endfunction

endpackage

/* design/string_hash_bucket_index_top.sv */
// djb2 (xor form) key hash with bucket select. Key bytes are taken one beat
// per cycle while the block hashes; a zero byte is not mixed in. On the beat
// marked last the 64-bit hash is latched and the block stalls its input
// while the bit-serial remainder unit works (one dividend bit a cycle) and
// until the output register is loaded, longer if the previous result is
// still held there. The result beat carries the hash and hash mod
// bucket_count; a bucket count of zero gives index 0. bucket_count resets
// to 16.
module string_hash_bucket_index_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [shbi_pkg::DIV_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [shbi_pkg::BYTE_W-1:0]   in_key_byte,
  input  logic                          in_last_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [shbi_pkg::HASH_W-1:0]   out_key_hash,
  output logic [shbi_pkg::DIV_W-1:0]    out_bucket_index
);
  import shbi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  shbi_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_byte (in_last_byte),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Hash, remainder unit and output register
  shbi_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_key_byte      (in_key_byte),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_key_hash     (out_key_hash),
    .out_bucket_index (out_bucket_index)
  );

endmodule

/* design/shbi_ctrl.sv */
module shbi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last_byte,
  output logic          in_stall,
  input  shbi_pkg::sts_t sts,
  output shbi_pkg::cmd_t cmd
);
  import shbi_pkg::*;

  state_t st_r, st_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_HASH;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Next state and commands; input is never stalled in ST_HASH
  always_comb begin
    st_nxt        = st_r;
    in_stall      = 1'b1;
    cmd           = '0;
    unique case (st_r)
      ST_HASH: begin
        in_stall = 1'b0;
        if (in_valid && in_last_byte) begin
          cmd.div_start = 1'b1;
          st_nxt        = ST_DIV;
        end else if (in_valid) begin
          cmd.hash_en = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          st_nxt       = ST_HASH;
        end
      end
      default: st_nxt = ST_HASH;
    endcase
  end

endmodule

/* design/shbi_dp.sv */
module shbi_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [shbi_pkg::DIV_W-1:0]    cfg_wdata,
  input  logic [shbi_pkg::BYTE_W-1:0]   in_key_byte,
  input  shbi_pkg::cmd_t                cmd,
  output shbi_pkg::sts_t                sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [shbi_pkg::HASH_W-1:0]   out_key_hash,
  output logic [shbi_pkg::DIV_W-1:0]    out_bucket_index
);
  import shbi_pkg::*;

  logic [DIV_W-1:0]  bucket_count_r;
  logic [HASH_W-1:0] hash_r;
  logic [HASH_W-1:0] hash_mix;
  logic [HASH_W-1:0] key_hash_r;
  logic [HASH_W-1:0] dvd_r;
  logic [DIV_W-1:0]  div_r;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              out_valid_r;
  logic [HASH_W-1:0] out_hash_r;
  logic [DIV_W-1:0]  out_idx_r;

  // Bucket count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= BUCKET_RST;
    end else if (cfg_we) begin
      bucket_count_r <= cfg_wdata;
    end
  end

  // Running hash
  assign hash_mix = mix_byte(hash_r, in_key_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= HASH_SEED;
    end else if (cmd.div_start) begin
      hash_r <= HASH_SEED;
    end else if (cmd.hash_en) begin
      hash_r <= hash_mix;
    end
  end

  // Restoring remainder step, one dividend bit per cycle
  assign trial = {rem_r, dvd_r[HASH_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign rem_nxt = diff[DIV_W] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      key_hash_r <= hash_mix;
      dvd_r      <= hash_mix;
      div_r      <= bucket_count_r;
      rem_r      <= '0;
      cnt_r      <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[HASH_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hash_r <= key_hash_r;
      out_idx_r  <= (div_r == '0) ? '0 : rem_r;
    end
  end

  assign sts.div_last  = (cnt_r == DIV_LAST_STEP);
  assign sts.out_busy  = out_valid_r && out_stall;

  assign out_valid        = out_valid_r;
  assign out_key_hash     = out_hash_r;
  assign out_bucket_index = out_idx_r;

endmodule

/* bench/tb_string_hash_bucket_index_top.sv */
`timescale 1ns / 100ps

module tb_string_hash_bucket_index_top;
  import shbi_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int RST_CYC = 12;
  // leave margin after the modulo unit before touching the register
  localparam int SETTLE_CYC = 80;
  localparam int RAND_BEATS = 1150;
  localparam longint TIMEOUT_NS = 64'd1_000_000 * 2 * CLK_HALF;
  localparam logic [HASH_W-1:0] DJB2_SEED = HASH_W'(5381);
  localparam logic [DIV_W-1:0] BUCKETS_AT_RST = DIV_W'(16);

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic last;
  } key_beat_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [DIV_W-1:0] bucket;
  } bucket_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [DIV_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [BYTE_W-1:0] in_key_byte = '0;
  logic in_last_byte = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [HASH_W-1:0] out_key_hash;
  logic [DIV_W-1:0] out_bucket_index;

  // key beats waiting to be sent, results waiting to come back
  key_beat_t beat_q[$];
  bucket_res_t bucket_q[$];

  // predictor copy of block state
  logic [HASH_W-1:0] key_hash_acc = DJB2_SEED;
  logic [DIV_W-1:0] bucket_div = BUCKETS_AT_RST;

  logic in_fire = 1'b0;
  int err_cnt = 0;
  int burst_left = 8;
  int gap_left = 0;
  bit steady_send = 1'b0;
  int stall_mode = 0;
  logic [31:0] stall_cyc = '0;
  key_beat_t nxt_beat;
  bucket_res_t want;

  string_hash_bucket_index_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_key_byte      (in_key_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_key_hash     (out_key_hash),
    .out_bucket_index (out_bucket_index)
  );

  always #(CLK_HALF) clk = ~clk;

  // one xor-djb2 step; zero bytes leave the hash alone
  function automatic logic [HASH_W-1:0] djb2x_mix(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] c);
    if (c == '0) begin
      return h;
    end
    return (h * HASH_W'(33)) ^ HASH_W'(c);
  endfunction

  function automatic logic [DIV_W-1:0] bucket_of(input logic [HASH_W-1:0] h,
                                                 input logic [DIV_W-1:0] n);
    if (n == '0) begin
      return '0;
    end
    return DIV_W'(h % HASH_W'(n));
  endfunction

  // byte mix: printable text, high bytes, zeros and the edge values
  function automatic logic [BYTE_W-1:0] pick_char();
    case ($urandom_range(0, 15))
      0: return 8'h00;
      1, 2: return 8'($urandom_range(128, 255));
      3: return 8'($urandom_range(1, 255));
      4: return 8'hFF;
      5: return 8'h01;
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  function automatic logic [DIV_W-1:0] pick_buckets();
    case ($urandom_range(0, 8))
      0: return DIV_W'(1);
      1: return '0;
      2: return 32'hFFFF_FFFF;
      3: return BUCKETS_AT_RST;
      4: return DIV_W'($urandom_range(2, 64));
      5: return DIV_W'($urandom());
      6: return 32'h8000_0000;
      7: return DIV_W'($urandom_range(1, 1000));
      default: return DIV_W'(1) << $urandom_range(0, 31);
    endcase
  endfunction

  function automatic int pick_len();
    case ($urandom_range(0, 19))
      0: return 1;
      1, 2, 3: return $urandom_range(11, 40);
      default: return $urandom_range(1, 10);
    endcase
  endfunction

  task automatic push_beat(input logic [BYTE_W-1:0] ch, input logic last);
    key_beat_t b;
    b.ch = ch;
    b.last = last;
    beat_q.push_back(b);
  endtask

  task automatic queue_key(input int len);
    for (int i = 0; i < len - 1; i++) begin
      push_beat(pick_char(), 1'b0);
    end
    push_beat(pick_char(), 1'b1);
  endtask

  // sender holds off until every beat is taken and every result is back
  task automatic wait_idle();
    @(posedge clk);
    #1;
    while (beat_q.size() != 0 || (in_valid && !in_fire) || bucket_q.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic set_buckets(input logic [DIV_W-1:0] n);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // predictor and result checker
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
    if (!rst_n) begin
      key_hash_acc = DJB2_SEED;
      bucket_div = BUCKETS_AT_RST;
    end else begin
      if (cfg_we) begin
        bucket_div = cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        key_hash_acc = djb2x_mix(key_hash_acc, in_key_byte);
        if (in_last_byte) begin
          bucket_q.push_back('{hash: key_hash_acc,
                               bucket: bucket_of(key_hash_acc, bucket_div)});
          key_hash_acc = DJB2_SEED;
        end
      end
      if (out_valid && !out_stall) begin
        if (bucket_q.size() == 0) begin
          $display("%0t: unexpected result beat: hash=%h index=%0d",
                   $time, out_key_hash, out_bucket_index);
          err_cnt++;
        end else begin
          want = bucket_q.pop_front();
          if (out_key_hash !== want.hash) begin
            $display("%0t: key_hash mismatch: expected %h, got %h",
                     $time, want.hash, out_key_hash);
            err_cnt++;
          end
          if (out_bucket_index !== want.bucket) begin
            $display("%0t: bucket_index mismatch: expected %0d, got %0d",
                     $time, want.bucket, out_bucket_index);
            err_cnt++;
          end
        end
      end
    end
  end

  // key byte driver: bursts of beats with random gaps, or none in steady mode
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // stalled beat stays put
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (beat_q.size() > 0) begin
      nxt_beat = beat_q.pop_front();
      in_valid <= 1'b1;
      in_key_byte <= nxt_beat.ch;
      in_last_byte <= nxt_beat.last;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = steady_send ? 0 : $urandom_range(1, 10);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result stall pattern, mode picked at random whenever the low byte of stall_cyc is zero
  always @(negedge clk) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc[7:0] == 8'd0) begin
      stall_mode = $urandom_range(0, 3);
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_cyc[3:2] == 2'b11);
    endcase
  end

  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int sent;
    int plan;
    int len;
    int phase_n;

    repeat (RST_CYC) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed keys at the reset bucket count
    push_beat(8'h00, 1'b1);           // empty key
    push_beat(8'hFF, 1'b1);
    push_beat(8'h01, 1'b1);
    push_beat("a", 1'b0);             // zero byte inside a key
    push_beat(8'h00, 1'b0);
    push_beat("b", 1'b0);
    push_beat("c", 1'b1);
    push_beat(8'h80, 1'b0);
    push_beat(8'h7F, 1'b1);
    push_beat(8'h00, 1'b0);           // zeros only
    push_beat(8'h00, 1'b1);
    wait_idle();

    // single bucket, then leave a key open across the next register write
    set_buckets(DIV_W'(1));
    push_beat("x", 1'b0);
    push_beat("y", 1'b1);
    push_beat("h", 1'b0);
    push_beat("e", 1'b0);
    wait_idle();

    // zero bucket count, written in mid-key
    set_buckets('0);
    push_beat("l", 1'b0);
    push_beat("l", 1'b0);
    push_beat("o", 1'b1);
    for (int i = 0; i < 5; i++) begin
      push_beat(8'hFF, 1'b0);
    end
    push_beat(8'hFF, 1'b1);

    // random keys, one bucket count per phase
    sent = 0;
    phase_n = 0;
    while (sent < RAND_BEATS) begin
      wait_idle();
      set_buckets(phase_n == 0 ? 32'hFFFF_FFFF : pick_buckets());
      steady_send = ($urandom_range(0, 3) == 0);
      plan = $urandom_range(40, 180);
      while (plan > 0) begin
        if ($urandom_range(0, 19) == 0) begin
          push_beat(8'h00, 1'b1);
          len = 1;
        end else begin
          len = pick_len();
          queue_key(len);
        end
        plan -= len;
        sent += len;
      end
      // sometimes end the phase with a key still open
      if ($urandom_range(0, 2) == 0) begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          push_beat(pick_char(), 1'b0);
        end
        sent += len;
      end
      phase_n++;
    end

    wait_idle();
    if (err_cnt == 0 && bucket_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
